// ----- rtl/hmq_pkg.sv -----
// Shared types and constants for the binary max-heap queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hmq_pkg;

    // Fixed field widths.
    localparam int KEY_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    // Result status codes.
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;

    // Operation codes carried on the mode field.
    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    // Key reported when the heap holds nothing.
    localparam logic signed [KEY_W-1:0] KEY_NONE = {KEY_W{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;       // capture an input beat and update the count
        logic rd_parent;    // read the parent of the hole
        logic rd_last;      // read the last key of the heap
        logic rd_children;  // read both children of the hole
        logic load_key;     // take the last key as the moving key, hole at the root
        logic step_up;      // move the parent down into the hole
        logic step_down;    // move the larger child up into the hole
        logic place;        // write the moving key into the hole
        logic publish;      // load the result registers
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;         // count equals capacity
        logic empty;        // count is zero
        logic one_left;     // count is one
        logic pos_zero;     // hole is at the root
        logic left_out;     // left child of the hole is beyond the heap
        logic up_move;      // parent is smaller than the moving key
        logic down_move;    // a child is larger than the moving key
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/hmq_ram.sv -----
// Generic simple dual-port RAM: one write port and two registered read ports.
// Standalone; holds the heap keys.
`timescale 1ns / 1ps
`default_nettype none

module hmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports.
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ----- rtl/hmq_ctrl.sv -----
// Controller state machine of the heap queue: sequences sift-up and sift-down.
// Depends on hmq_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module hmq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_mode,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire hmq_pkg::t_sts i_sts,
    output hmq_pkg::t_cmd      o_cmd
);

    import hmq_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_RD   = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_DN_LAST = 3'd3;
    localparam logic [2:0] S_DN_LDK  = 3'd4;
    localparam logic [2:0] S_DN_RD   = 3'd5;
    localparam logic [2:0] S_DN_CMP  = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_cmd       cmd;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    if (i_mode == MODE_INSERT) begin
                        n_state = i_sts.full ? S_DONE : S_UP_RD;
                    end else if (i_sts.empty || i_sts.one_left) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DN_LAST;
                    end
                end
            end
            S_UP_RD: begin
                if (i_sts.pos_zero) begin
                    cmd.place = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    cmd.rd_parent = 1'b1;
                    n_state       = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_sts.up_move) begin
                    cmd.step_up = 1'b1;
                    n_state     = S_UP_RD;
                end else begin
                    cmd.place = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_DN_LAST: begin
                cmd.rd_last = 1'b1;
                n_state     = S_DN_LDK;
            end
            S_DN_LDK: begin
                cmd.load_key = 1'b1;
                n_state      = S_DN_RD;
            end
            S_DN_RD: begin
                if (i_sts.left_out) begin
                    cmd.place = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    cmd.rd_children = 1'b1;
                    n_state         = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_sts.down_move) begin
                    cmd.step_down = 1'b1;
                    n_state       = S_DN_RD;
                end else begin
                    cmd.place = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.publish = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The result register is filled on publish and drained by the output beat.
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // An accepted beat always leaves the idle state, so no second beat follows at once.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken on two consecutive cycles");

    // A pending result is never overwritten.
    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result published while the previous one still waits");

    // A parent or child comparison always follows its read.
    a_cmp_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_CMP || r_state == S_DN_CMP) |->
        ($past(r_state) == S_UP_RD || $past(r_state) == S_DN_RD))
        else $error("comparison without a preceding read");

endmodule

`default_nettype wire

// ----- rtl/hmq_dp.sv -----
// Datapath of the heap queue: count, hole position, moving key, key RAM, result registers.
// Depends on hmq_pkg and instantiates hmq_ram.
`timescale 1ns / 1ps
`default_nettype none

module hmq_dp #(
    parameter int CAPACITY = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_mode,
    input  wire logic signed [hmq_pkg::KEY_W-1:0]  i_key,
    input  wire hmq_pkg::t_cmd                     i_cmd,
    output hmq_pkg::t_sts                          o_sts,
    output hmq_pkg::t_status                       o_status,
    output logic signed [hmq_pkg::KEY_W-1:0]       o_top_key,
    output logic [hmq_pkg::COUNT_OUT_W-1:0]        o_entry_count
);

    import hmq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 1;

    logic [CW-1:0]              r_count;
    logic [AW-1:0]              r_pos;
    logic signed [KEY_W-1:0]    r_key;
    logic signed [KEY_W-1:0]    r_root;
    t_status                    r_status;
    t_status                    r_out_status;
    logic signed [KEY_W-1:0]    r_out_top;
    logic [COUNT_OUT_W-1:0]     r_out_count;

    logic [AW-1:0]              parent;
    logic [LW-1:0]              left_idx;
    logic [LW-1:0]              right_idx;
    logic [LW-1:0]              count_ext;
    logic                       left_ok;
    logic                       right_ok;
    logic [KEY_W-1:0]           qa;
    logic [KEY_W-1:0]           qb;
    logic                       c_lk;
    logic                       c_rk;
    logic                       c_rl;
    logic                       take_l;
    logic                       take_r;
    logic [LW-1:0]              best_idx;
    logic [KEY_W-1:0]           best_val;
    logic                       full;
    logic                       empty;
    logic                       we;
    logic [AW-1:0]              waddr;
    logic [KEY_W-1:0]           wdata;
    logic [AW-1:0]              raddr_a;
    logic [AW-1:0]              raddr_b;

    // Heap index arithmetic around the hole.
    assign parent    = (r_pos - AW'(1)) >> 1;
    assign left_idx  = {r_pos, 1'b1};
    assign right_idx = left_idx + LW'(1);
    assign count_ext = LW'(r_count);
    assign left_ok   = (left_idx < count_ext);
    assign right_ok  = (right_idx < count_ext);
    assign full      = (r_count == CW'(CAPACITY));
    assign empty     = (r_count == '0);

    // Child selection: strictly larger moves, the left child wins a tie.
    assign c_lk     = ($signed(qa) > r_key);
    assign c_rk     = ($signed(qb) > r_key);
    assign c_rl     = ($signed(qb) > $signed(qa));
    assign take_l   = left_ok && c_lk;
    assign take_r   = right_ok && (take_l ? c_rl : c_rk);
    assign best_idx = take_r ? right_idx : left_idx;
    assign best_val = take_r ? qb : qa;

    // Read address selection.
    always_comb begin
        raddr_a = parent;
        raddr_b = left_idx[AW-1:0];
        if (i_cmd.rd_last) begin
            raddr_a = AW'(r_count);
        end else if (i_cmd.rd_children) begin
            raddr_a = left_idx[AW-1:0];
            raddr_b = right_ok ? right_idx[AW-1:0] : left_idx[AW-1:0];
        end
    end

    // Write port: every write lands in the hole.
    always_comb begin
        we    = i_cmd.place || i_cmd.step_up || i_cmd.step_down;
        waddr = r_pos;
        wdata = r_key;
        if (i_cmd.step_up) begin
            wdata = qa;
        end else if (i_cmd.step_down) begin
            wdata = best_val;
        end
    end

    hmq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (qa),
        .o_rdata_b (qb)
    );

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.accept) begin
            if (i_mode == MODE_INSERT && !full) begin
                r_count <= r_count + CW'(1);
            end else if (i_mode == MODE_EXTRACT && !empty) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Hole position, moving key and status of the beat in flight.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key <= i_key;
            r_pos <= AW'(r_count);
            if (i_mode == MODE_INSERT) begin
                r_status <= full ? STATUS_FULL : STATUS_OK;
            end else begin
                r_status <= empty ? STATUS_EMPTY : STATUS_OK;
            end
        end else if (i_cmd.load_key) begin
            r_key <= $signed(qa);
            r_pos <= '0;
        end else if (i_cmd.step_up) begin
            r_pos <= parent;
        end else if (i_cmd.step_down) begin
            r_pos <= best_idx[AW-1:0];
        end
    end

    // Copy of the root; each operation writes address zero at most once.
    always_ff @(posedge i_clk) begin
        if (we && waddr == '0) begin
            r_root <= $signed(wdata);
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_status <= r_status;
            r_out_top    <= empty ? KEY_NONE : r_root;
            r_out_count  <= COUNT_OUT_W'(r_count);
        end
    end

    assign o_sts.full      = full;
    assign o_sts.empty     = empty;
    assign o_sts.one_left  = (r_count == CW'(1));
    assign o_sts.pos_zero  = (r_pos == '0);
    assign o_sts.left_out  = !left_ok;
    assign o_sts.up_move   = ($signed(qa) < r_key);
    assign o_sts.down_move = take_l || take_r;

    assign o_status      = r_out_status;
    assign o_top_key     = r_out_top;
    assign o_entry_count = r_out_count;

    // The heap never holds more keys than it has room for.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // Writes only touch slots inside the heap.
    a_write_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (LW'(waddr) < count_ext))
        else $error("key written beyond the heap");

    // After a child moves up, the hole sits deeper in the tree.
    a_down_deeper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step_down |=> (r_pos > $past(r_pos)))
        else $error("sift-down did not descend");

endmodule

`default_nettype wire

// ----- rtl/binary_max_heap_queue.sv -----
// Channel  | Direction | Handshake               | Payload
// input    | in        | i_in_valid / o_in_ready | i_mode, i_key
// result   | out       | o_out_valid / i_out_ready | o_status, o_top_key, o_entry_count
//
// One beat is worked at a time. An insert reads parent keys until the moving key finds its
// place; an extract first reads the last key and moves it to the root, then reads child
// pairs. A refused insert, a removal from an empty heap and a removal of the last key
// go straight to publishing the result.
// Each tree level has two steps: one to address the key RAM, one for its registered
// read data to be compared and the hole to be written.
// Reset (synchronous, active low) empties the heap; the key RAM itself is not cleared.
// A new beat is taken while the previous result still waits in the output register.
// Top level of the binary max-heap queue; depends on hmq_pkg, hmq_ctrl and hmq_dp.
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_queue #(
    parameter int CAPACITY = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_mode,
    input  wire logic signed [hmq_pkg::KEY_W-1:0]  i_key,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output hmq_pkg::t_status                       o_status,
    output logic signed [hmq_pkg::KEY_W-1:0]       o_top_key,
    output logic [hmq_pkg::COUNT_OUT_W-1:0]        o_entry_count
);

    import hmq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    hmq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    hmq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_status      (o_status),
        .o_top_key     (o_top_key),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire
